>>> rtl/hsvc_pkg.sv
// Shared types and constants for the HSV color classifier.
// Used by the core, the pipelined divider and the port checker; no dependencies.
`default_nettype none

package hsvc_pkg;

    // Channel and field widths.
    localparam int RAW_W     = 10;
    localparam int CH_W      = 8;
    localparam int HUE_W     = 13;
    localparam int CLASS_W   = 3;
    localparam int WIN_W     = 42;
    localparam int CFG_IDX_W = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Divider geometry: 18-bit dividend, 8-bit divisor, 10-bit quotient,
    // two quotient bits resolved per pipeline stage.
    localparam int DIV_NUM_W    = 18;
    localparam int DIV_DEN_W    = 8;
    localparam int DIV_QUO_W    = 10;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = DIV_QUO_W / DIV_STEPS;

    // Hue offsets in sixteenths of a degree.
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL       = 13'd5760;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_MAX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_WIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WIN  = 3'd5;

    // Window field positions.
    localparam int WIN_HMIN_LSB = 0;
    localparam int WIN_HMAX_LSB = 13;
    localparam int WIN_SMIN_LSB = 26;
    localparam int WIN_SMAX_LSB = 34;

    typedef enum logic [CLASS_W-1:0] {
        CLS_BLACK   = 3'd0,
        CLS_WHITE   = 3'd1,
        CLS_RED     = 3'd2,
        CLS_YELLOW  = 3'd3,
        CLS_GREEN   = 3'd4,
        CLS_BLUE    = 3'd5,
        CLS_UNKNOWN = 3'd6
    } color_class_t;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // Per-item information that rides alongside the divider stages.
    typedef struct packed {
        logic            hue_valid;
        logic            neg;
        sector_t         sector;
        logic [CH_W-1:0] bright;
    } side_t;

endpackage

`default_nettype wire

>>> rtl/hsvc_div.sv
// Pipelined restoring divider, two quotient bits per stage.
// Depends on hsvc_pkg for its widths; stage enables come from the core's flow control.
`default_nettype none

module hsvc_div (
    input  wire logic                             clk,
    input  wire logic [hsvc_pkg::DIV_STAGES-1:0]  en,
    input  wire logic [hsvc_pkg::DIV_NUM_W-1:0]   num,
    input  wire logic [hsvc_pkg::DIV_DEN_W-1:0]   den,
    output logic      [hsvc_pkg::DIV_QUO_W-1:0]   quo,
    output logic                                  rem_nz
);
    import hsvc_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [DIV_QUO_W-1:0] low_reg  [DIV_STAGES];
    logic [DIV_QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_STAGES];

    logic [DIV_DEN_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_QUO_W-1:0] low_next [DIV_STAGES];
    logic [DIV_QUO_W-1:0] quo_next [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_next [DIV_STAGES];

    // The partial remainder stays below the divisor, so each step is one
    // 9-bit compare and subtract.
    always_comb
    begin
        logic [DIV_DEN_W-1:0] r;
        logic [DIV_QUO_W-1:0] lo;
        logic [DIV_QUO_W-1:0] q;
        logic [DIV_DEN_W-1:0] d;
        logic [DIV_DEN_W:0]   t;
        logic [DIV_DEN_W:0]   diff;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r  = num[DIV_NUM_W-1:DIV_QUO_W];
                lo = num[DIV_QUO_W-1:0];
                q  = '0;
                d  = den;
            end
            else
            begin
                r  = rem_reg[s-1];
                lo = low_reg[s-1];
                q  = quo_reg[s-1];
                d  = den_reg[s-1];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                t    = {r, lo[DIV_QUO_W-1]};
                lo   = {lo[DIV_QUO_W-2:0], 1'b0};
                diff = t - {1'b0, d};
                if (t >= {1'b0, d})
                begin
                    r = diff[DIV_DEN_W-1:0];
                    q = {q[DIV_QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r = t[DIV_DEN_W-1:0];
                    q = {q[DIV_QUO_W-2:0], 1'b0};
                end
            end
            rem_next[s] = r;
            low_next[s] = lo;
            quo_next[s] = q;
            den_next[s] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quo    = quo_reg[DIV_STAGES-1];
    assign rem_nz = (rem_reg[DIV_STAGES-1] != '0);

endmodule

`default_nettype wire

>>> rtl/hsv_color_classifier_core.sv
// Channel   | Direction | Handshake           | Payload
// s_*       | in        | s_tvalid / s_tready | red, green, blue, ambient raw readings
// m_*       | out       | m_tvalid / m_tready | class, hue, hue valid, saturation, brightness
// cfg_*     | in        | cfg_valid/cfg_ready | register index and write data
//
// One transaction per cycle in and out while the output is not stalled; the two 10-bit
// quotient dividers resolve two bits per stage. Reset clears the stage valid bits, the
// black threshold and the windows, and sets the white threshold to all ones.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and a stall neither drops nor repeats an item. cfg_ready is always high.
`default_nettype none

module hsv_color_classifier_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [9:0] red_raw, [19:10] green_raw, [29:20] blue_raw, [39:30] ambient_raw
    input  wire logic [hsvc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] color_class, [15:3] hue, [16] hue_valid, [24:17] saturation,
    // [32:25] brightness, [39:33] zero
    output logic      [hsvc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hsvc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hsvc_pkg::WIN_W-1:0]        cfg_data
);
    import hsvc_pkg::*;

    localparam int DIV_FST = 3;
    localparam int FIN_STG = DIV_FST + DIV_STAGES;
    localparam int OUT_STG = FIN_STG + 1;
    localparam int NSTG    = OUT_STG + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  black_max_reg;
    logic [CH_W-1:0]  white_min_reg;
    logic [WIN_W-1:0] win_reg [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_max_reg <= '0;
            white_min_reg <= '1;
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BLACK_MAX:  black_max_reg <= cfg_data[CH_W-1:0];
                REG_WHITE_MIN:  white_min_reg <= cfg_data[CH_W-1:0];
                REG_RED_WIN:    win_reg[0]    <= cfg_data;
                REG_YELLOW_WIN: win_reg[1]    <= cfg_data;
                REG_GREEN_WIN:  win_reg[2]    <= cfg_data;
                REG_BLUE_WIN:   win_reg[3]    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: add ambient and clamp.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] r0_reg, g0_reg, b0_reg;

    function automatic logic [CH_W-1:0] clamp_sum(input logic [RAW_W-1:0] a,
                                                  input logic [RAW_W-1:0] amb);
        logic [RAW_W:0] s;
        s = {1'b0, a} + {1'b0, amb};
        return (s > 11'd255) ? 8'hFF : s[CH_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            r0_reg <= clamp_sum(s_tdata[9:0],   s_tdata[39:30]);
            g0_reg <= clamp_sum(s_tdata[19:10], s_tdata[39:30]);
            b0_reg <= clamp_sum(s_tdata[29:20], s_tdata[39:30]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: max, min, chroma and the signed hue numerator.
    // ------------------------------------------------------------------
    sector_t         sec1_next, sec1_reg;
    logic [CH_W-1:0] v1_next, v1_reg;
    logic [CH_W-1:0] c1_next, c1_reg;
    logic [CH_W-1:0] absn1_next, absn1_reg;
    logic            neg1_next, neg1_reg;

    always_comb
    begin
        logic [CH_W:0]   diff;
        logic [CH_W:0]   negd;
        logic [CH_W-1:0] mn;
        // Ties go to red first, then green.
        if (r0_reg >= g0_reg && r0_reg >= b0_reg)
        begin
            sec1_next = SEC_RED;
            v1_next   = r0_reg;
            diff      = {1'b0, g0_reg} - {1'b0, b0_reg};
        end
        else if (g0_reg >= b0_reg)
        begin
            sec1_next = SEC_GREEN;
            v1_next   = g0_reg;
            diff      = {1'b0, b0_reg} - {1'b0, r0_reg};
        end
        else
        begin
            sec1_next = SEC_BLUE;
            v1_next   = b0_reg;
            diff      = {1'b0, r0_reg} - {1'b0, g0_reg};
        end
        mn = r0_reg;
        if (g0_reg < mn)
        begin
            mn = g0_reg;
        end
        if (b0_reg < mn)
        begin
            mn = b0_reg;
        end
        c1_next    = v1_next - mn;
        negd       = -diff;
        neg1_next  = diff[CH_W];
        absn1_next = diff[CH_W] ? negd[CH_W-1:0] : diff[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sec1_reg  <= sec1_next;
            v1_reg    <= v1_next;
            c1_reg    <= c1_next;
            absn1_reg <= absn1_next;
            neg1_reg  <= neg1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scaled dividends, 960*|num| and 255*chroma.
    // ------------------------------------------------------------------
    logic [DIV_NUM_W-1:0] nhue2_reg, nsat2_reg;
    logic [CH_W-1:0]      c2_reg;
    side_t                side2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            nhue2_reg <= {absn1_reg, 10'b0} - {4'b0, absn1_reg, 6'b0};
            nsat2_reg <= {2'b0, c1_reg, 8'b0} - {10'b0, c1_reg};
            c2_reg    <= c1_reg;
            side2_reg <= '{hue_valid: (c1_reg != '0), neg: neg1_reg,
                           sector: sec1_reg, bright: v1_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..7: the two dividers, with the side information alongside.
    // ------------------------------------------------------------------
    logic [DIV_QUO_W-1:0] hue_quo, sat_quo;
    logic                 hue_rem_nz;
    logic                 sat_rem_unused;
    side_t                side_reg [DIV_STAGES];

    hsvc_div u_hue_div (
        .clk    (clk),
        .en     (adv[FIN_STG-1:DIV_FST]),
        .num    (nhue2_reg),
        .den    (c2_reg),
        .quo    (hue_quo),
        .rem_nz (hue_rem_nz)
    );

    hsvc_div u_sat_div (
        .clk    (clk),
        .en     (adv[FIN_STG-1:DIV_FST]),
        .num    (nsat2_reg),
        .den    (side2_reg.bright),
        .quo    (sat_quo),
        .rem_nz (sat_rem_unused)
    );

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (adv[DIV_FST+s])
            begin
                side_reg[s] <= (s == 0) ? side2_reg : side_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: hue from sector offset and quotient, saturation guard.
    // ------------------------------------------------------------------
    side_t           side_fin;
    logic [HUE_W-1:0] hue8_next, hue8_reg;
    logic [CH_W-1:0]  sat8_next, sat8_reg;
    logic             hv8_reg;
    logic [CH_W-1:0]  v8_reg;

    assign side_fin = side_reg[DIV_STAGES-1];

    always_comb
    begin
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] qx;
        unique case (side_fin.sector)
            SEC_RED:   base = side_fin.neg ? HUE_FULL : '0;
            SEC_GREEN: base = HUE_GREEN_BASE;
            SEC_BLUE:  base = HUE_BLUE_BASE;
            default:   base = '0;
        endcase
        qx = {{(HUE_W-DIV_QUO_W){1'b0}}, hue_quo};
        // A negative numerator rounds toward minus infinity: subtract the ceiling.
        if (!side_fin.hue_valid)
        begin
            hue8_next = '0;
        end
        else if (side_fin.neg)
        begin
            hue8_next = base - qx - {{(HUE_W-1){1'b0}}, hue_rem_nz};
        end
        else
        begin
            hue8_next = base + qx;
        end
        // Zero brightness gives zero saturation; the divisor is meaningless then.
        sat8_next = (side_fin.bright == '0) ? '0 : sat_quo[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[FIN_STG])
        begin
            hue8_reg <= hue8_next;
            sat8_reg <= sat8_next;
            hv8_reg  <= side_fin.hue_valid;
            v8_reg   <= side_fin.bright;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: classification into the output register.
    // ------------------------------------------------------------------
    function automatic logic win_hit(input logic [WIN_W-1:0] w,
                                     input logic [HUE_W-1:0] h,
                                     input logic [CH_W-1:0]  s);
        logic [HUE_W-1:0] hmin, hmax;
        logic [CH_W-1:0]  smin, smax;
        hmin = w[WIN_HMIN_LSB +: HUE_W];
        hmax = w[WIN_HMAX_LSB +: HUE_W];
        smin = w[WIN_SMIN_LSB +: CH_W];
        smax = w[WIN_SMAX_LSB +: CH_W];
        return (h >= hmin) && (h <= hmax) && (s >= smin) && (s <= smax);
    endfunction

    color_class_t    cls_next, cls_reg;
    logic [HUE_W-1:0] hue_out_reg;
    logic [CH_W-1:0]  sat_out_reg;
    logic [CH_W-1:0]  v_out_reg;
    logic             hv_out_reg;

    always_comb
    begin
        priority if (v8_reg < black_max_reg)
        begin
            cls_next = CLS_BLACK;
        end
        else if (v8_reg > white_min_reg)
        begin
            cls_next = CLS_WHITE;
        end
        else if (hv8_reg && win_hit(win_reg[0], hue8_reg, sat8_reg))
        begin
            cls_next = CLS_RED;
        end
        else if (hv8_reg && win_hit(win_reg[1], hue8_reg, sat8_reg))
        begin
            cls_next = CLS_YELLOW;
        end
        else if (hv8_reg && win_hit(win_reg[2], hue8_reg, sat8_reg))
        begin
            cls_next = CLS_GREEN;
        end
        else if (hv8_reg && win_hit(win_reg[3], hue8_reg, sat8_reg))
        begin
            cls_next = CLS_BLUE;
        end
        else
        begin
            cls_next = CLS_UNKNOWN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT_STG])
        begin
            cls_reg     <= cls_next;
            hue_out_reg <= hue8_reg;
            hv_out_reg  <= hv8_reg;
            sat_out_reg <= sat8_reg;
            v_out_reg   <= v8_reg;
        end
    end

    assign m_tvalid = vld_reg[OUT_STG];
    assign m_tdata  = {7'b0, v_out_reg, sat_out_reg, hv_out_reg, hue_out_reg, cls_reg};

endmodule

`default_nettype wire

>>> rtl/hsvc_checker.sv
// Port-level checker for the HSV color classifier core, attached by bind.
// Depends on hsvc_pkg for widths and class codes.
`default_nettype none

module hsvc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [hsvc_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [hsvc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready
);
    import hsvc_pkg::*;

    logic [CLASS_W-1:0] out_cls;
    logic [HUE_W-1:0]   out_hue;
    logic               out_hv;

    assign out_cls = m_tdata[2:0];
    assign out_hue = m_tdata[15:3];
    assign out_hv  = m_tdata[16];

    // A stalled result stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // With the sink ready the pipeline never pushes back on the source.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output side ready");

    // An undefined hue is reported as zero.
    a_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_hv |-> out_hue == '0)
        else $error("hue nonzero while hue_valid is low");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_hue < HUE_FULL)
        else $error("hue out of range");

    // A hue-window class requires a defined hue.
    a_color_needs_hue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_cls == CLS_RED || out_cls == CLS_YELLOW ||
                     out_cls == CLS_GREEN || out_cls == CLS_BLUE) |-> out_hv)
        else $error("color class given without a valid hue");

    logic unused_ok;
    assign unused_ok = s_tvalid ^ (^s_tdata) ^ cfg_valid ^ cfg_ready;

endmodule

bind hsv_color_classifier_core hsvc_checker u_hsvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hsv_color_classifier_core: predicts each class/HSV result
// in place and compares it with the output stream. Needs rtl/hsvc_pkg.sv and the core.

module testbench;

    import hsvc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HUE_SECTOR  = 960;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Fields from the lowest bit up: red, green, blue, ambient.
    typedef struct packed {
        logic [RAW_W-1:0] ambient_raw;
        logic [RAW_W-1:0] blue_raw;
        logic [RAW_W-1:0] green_raw;
        logic [RAW_W-1:0] red_raw;
    } rgb_sample_t;

    // Fields from the lowest bit up: class, hue, hue valid, saturation, brightness, pad.
    typedef struct packed {
        logic [6:0]       pad;
        logic [CH_W-1:0]  brightness;
        logic [CH_W-1:0]  saturation;
        logic             hue_valid;
        logic [HUE_W-1:0] hue;
        color_class_t     cls;
    } hsv_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0]     cfg_data  = '0;

    // Shadow copy of the configuration registers.
    logic [CH_W-1:0]  black_max = 8'd0;
    logic [CH_W-1:0]  white_min = 8'd255;
    logic [WIN_W-1:0] win_regs [4];

    hsv_result_t expected_q [$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          hold_left   = 0;

    hsv_color_classifier_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int clamp_sum(input logic [RAW_W-1:0] raw, input logic [RAW_W-1:0] amb);
        int s;
        s = int'(raw) + int'(amb);
        return (s > 255) ? 255 : s;
    endfunction

    function automatic bit window_hit(input logic [WIN_W-1:0] w, input int hue, input int sat);
        return hue >= int'(w[WIN_HMIN_LSB +: HUE_W]) && hue <= int'(w[WIN_HMAX_LSB +: HUE_W])
            && sat >= int'(w[WIN_SMIN_LSB +: CH_W]) && sat <= int'(w[WIN_SMAX_LSB +: CH_W]);
    endfunction

    function automatic logic [WIN_W-1:0] pack_window(input int hmin, input int hmax,
                                                     input int smin, input int smax);
        return {smax[7:0], smin[7:0], hmax[12:0], hmin[12:0]};
    endfunction

    function automatic rgb_sample_t mk_sample(input int r, input int g, input int b, input int a);
        rgb_sample_t smp;
        smp.red_raw     = r[RAW_W-1:0];
        smp.green_raw   = g[RAW_W-1:0];
        smp.blue_raw    = b[RAW_W-1:0];
        smp.ambient_raw = a[RAW_W-1:0];
        return smp;
    endfunction

    function automatic hsv_result_t classify(input rgb_sample_t smp);
        hsv_result_t res;
        int r, g, b, v, mn, c, sat, num, base, t, h;
        bit hit;
        r = clamp_sum(smp.red_raw, smp.ambient_raw);
        g = clamp_sum(smp.green_raw, smp.ambient_raw);
        b = clamp_sum(smp.blue_raw, smp.ambient_raw);
        v = r;
        if (g > v) v = g;
        if (b > v) v = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = v - mn;
        sat = (v > 0) ? (255 * c) / v : 0;
        h = 0;
        res = '0;
        res.hue_valid = (c > 0);
        if (c > 0)
        begin
            // Ties go to red first, then green.
            if (v == r)
            begin
                num = g - b;
                base = 0;
            end
            else if (v == g)
            begin
                num = b - r;
                base = int'(HUE_GREEN_BASE);
            end
            else
            begin
                num = r - g;
                base = int'(HUE_BLUE_BASE);
            end
            // Floor toward minus infinity, then wrap a negative red-sector hue.
            t = HUE_SECTOR * num;
            h = (t >= 0) ? t / c : -((-t + c - 1) / c);
            h = h + base;
            if (h < 0) h = h + int'(HUE_FULL);
            res.hue = h[HUE_W-1:0];
        end
        res.saturation = sat[CH_W-1:0];
        res.brightness = v[CH_W-1:0];
        if (v < int'(black_max))
            res.cls = CLS_BLACK;
        else if (v > int'(white_min))
            res.cls = CLS_WHITE;
        else
        begin
            res.cls = CLS_UNKNOWN;
            hit = 1'b0;
            if (c > 0)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (!hit && window_hit(win_regs[i], h, sat))
                    begin
                        hit = 1'b1;
                        res.cls = color_class_t'(int'(CLS_RED) + i);
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic rgb_sample_t random_sample();
        int pick, lvl;
        pick = $urandom_range(9);
        lvl  = $urandom_range(255);
        case (pick)
            0, 1:
                return mk_sample($urandom_range(1023), $urandom_range(1023),
                                 $urandom_range(1023), $urandom_range(1023));
            2:
                return mk_sample(lvl, lvl, lvl, $urandom_range(40));
            3:
                return mk_sample(lvl, lvl, $urandom_range(255), $urandom_range(10));
            4:
                return mk_sample($urandom_range(255), lvl, lvl, $urandom_range(10));
            default:
                return mk_sample($urandom_range(255), $urandom_range(255),
                                 $urandom_range(255), $urandom_range(15));
        endcase
    endfunction

    // Output side: random stalls, plus an optional long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        hsv_result_t got;
        hsv_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = hsv_result_t'(m_tdata);
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction, tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.cls !== want.cls)
                begin
                    $error("color_class expected %0d actual %0d", want.cls, got.cls);
                    fail_count++;
                end
                if (got.hue !== want.hue)
                begin
                    $error("hue expected %0d actual %0d", want.hue, got.hue);
                    fail_count++;
                end
                if (got.hue_valid !== want.hue_valid)
                begin
                    $error("hue_valid expected %0d actual %0d", want.hue_valid, got.hue_valid);
                    fail_count++;
                end
                if (got.saturation !== want.saturation)
                begin
                    $error("saturation expected %0d actual %0d", want.saturation,
                           got.saturation);
                    fail_count++;
                end
                if (got.brightness !== want.brightness)
                begin
                    $error("brightness expected %0d actual %0d", want.brightness,
                           got.brightness);
                    fail_count++;
                end
                if (got.pad !== want.pad)
                begin
                    $error("pad expected %0d actual %0d", want.pad, got.pad);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One input transaction; the expectation is queued at the accepting edge.
    task automatic push_sample(input rgb_sample_t smp);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_q.push_back(classify(smp));
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            push_sample(random_sample());
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_BLACK_MAX:  black_max = val[CH_W-1:0];
            REG_WHITE_MIN:  white_min = val[CH_W-1:0];
            REG_RED_WIN:    win_regs[0] = val;
            REG_YELLOW_WIN: win_regs[1] = val;
            REG_GREEN_WIN:  win_regs[2] = val;
            REG_BLUE_WIN:   win_regs[3] = val;
            default:        ;
        endcase
    endtask

    task automatic apply_config(input logic [WIN_W-1:0] black, input logic [WIN_W-1:0] white,
                                input logic [WIN_W-1:0] w_red, input logic [WIN_W-1:0] w_yel,
                                input logic [WIN_W-1:0] w_grn, input logic [WIN_W-1:0] w_blu);
        write_reg(REG_BLACK_MAX, black);
        write_reg(REG_WHITE_MIN, white);
        write_reg(REG_RED_WIN, w_red);
        write_reg(REG_YELLOW_WIN, w_yel);
        write_reg(REG_GREEN_WIN, w_grn);
        write_reg(REG_BLUE_WIN, w_blu);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        push_sample(mk_sample(0, 0, 0, 0));
        push_sample(mk_sample(1023, 1023, 1023, 1023));
        push_sample(mk_sample(200, 50, 10, 0));
    endtask

    task automatic test_directed();
        wait_for_drain();
        apply_config(42'd20, 42'd240,
                     pack_window(0, 479, 64, 255), pack_window(480, 1439, 64, 255),
                     pack_window(1440, 2879, 32, 255), pack_window(2880, 4319, 32, 255));
        push_sample(mk_sample(1023, 1023, 1023, 1023));
        push_sample(mk_sample(0, 0, 0, 0));
        push_sample(mk_sample(200, 0, 0, 0));
        push_sample(mk_sample(0, 200, 0, 0));
        push_sample(mk_sample(0, 0, 200, 0));
        // Red largest with blue above green gives a negative hue that wraps.
        push_sample(mk_sample(200, 0, 100, 0));
        push_sample(mk_sample(200, 200, 0, 0));
        push_sample(mk_sample(0, 200, 200, 0));
        push_sample(mk_sample(200, 0, 200, 0));
        push_sample(mk_sample(100, 100, 100, 0));
        push_sample(mk_sample(100, 0, 0, 200));
        push_sample(mk_sample(19, 0, 0, 0));
        push_sample(mk_sample(20, 0, 0, 0));
        push_sample(mk_sample(241, 0, 0, 0));
        push_sample(mk_sample(240, 0, 0, 0));
        push_sample(mk_sample(200, 150, 100, 0));
        push_sample(mk_sample(1023, 0, 0, 0));
        push_sample(mk_sample(0, 0, 0, 255));
    endtask

    task automatic test_typical_windows();
        idle_pct  = 0;
        stall_pct = 0;
        run_random(250);
    endtask

    task automatic test_threshold_extremes();
        idle_pct  = 57;
        stall_pct = 0;
        for (int k = 0; k < 4; k++)
        begin
            wait_for_drain();
            case (k)
                0: apply_config(42'd255, 42'd0, '0, '0, '0, '0);
                1: apply_config(42'd0, 42'd0, pack_window(0, 8191, 0, 255), '0, '0, '0);
                2: apply_config(42'd255, 42'd255, '0, '0, '0, pack_window(0, 8191, 0, 255));
                // All-ones window, two min-above-max windows, then a catch-all.
                default: apply_config(42'd0, 42'd255, '1, pack_window(3000, 1000, 0, 255),
                                      pack_window(0, 5759, 200, 100),
                                      pack_window(0, 8191, 0, 255));
            endcase
            run_random(40);
        end
    endtask

    task automatic test_random_windows();
        logic [WIN_W-1:0] w [4];
        logic [WIN_W-1:0] black_word;
        int hmin;
        int smin;
        idle_pct  = 0;
        stall_pct = 57;
        for (int k = 0; k < 3; k++)
        begin
            wait_for_drain();
            for (int i = 0; i < 4; i++)
            begin
                if ($urandom_range(9) < 6)
                begin
                    hmin = $urandom_range(5759);
                    smin = $urandom_range(128);
                    w[i] = pack_window(hmin, hmin + $urandom_range(1500), smin,
                                       smin + $urandom_range(255 - smin));
                end
                else
                    w[i] = 42'({$urandom, $urandom});
            end
            // Upper bits of a byte register are dropped.
            black_word = 42'({$urandom, $urandom});
            black_word[CH_W-1:0] = 8'($urandom_range(60));
            write_reg(REG_SPARE_LO, 42'({$urandom, $urandom}));
            write_reg(REG_SPARE_HI, 42'({$urandom, $urandom}));
            apply_config(black_word, 42'($urandom_range(255, 180)), w[0], w[1], w[2], w[3]);
            run_random(100);
        end
    endtask

    task automatic test_overlapping_windows();
        wait_for_drain();
        idle_pct  = 30;
        stall_pct = 30;
        // Every window spans the whole hue range, so priority decides.
        apply_config(42'd0, 42'd255,
                     pack_window(0, 8191, 200, 255), pack_window(0, 8191, 120, 230),
                     pack_window(0, 8191, 60, 150), pack_window(0, 8191, 0, 90));
        run_random(300);
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        idle_pct  = 0;
        stall_pct = 0;
        apply_config(42'd10, 42'd250,
                     pack_window(0, 959, 40, 255), pack_window(960, 1919, 40, 255),
                     pack_window(1920, 3359, 40, 255), pack_window(3360, 4799, 40, 255));
        hold_left = 300;
        run_random(60);
    endtask

    initial
    begin
        win_regs = '{default: '0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_typical_windows();
        test_threshold_extremes();
        test_random_windows();
        test_overlapping_windows();
        test_backpressure();
        wait_for_drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
